// ----- sv/olt_pkg.sv -----
// shared types and codes for the owner lock table
package olt_pkg;

    localparam int ENTRIES_DEF = 256;

    localparam logic [1:0] CMD_LOCK   = 2'd0;
    localparam logic [1:0] CMD_UNLOCK = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_FULL        = 3'd1;
    localparam logic [2:0] STATUS_LOCKED      = 3'd2;
    localparam logic [2:0] STATUS_NOT_LOCKED  = 3'd3;
    localparam logic [2:0] STATUS_WRONG_OWNER = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [31:0] file_key;
        logic [15:0] sentence;
        logic        locked;
        logic [15:0] owner;
    } entry_t;

endpackage

// ----- sv/olt_store.sv -----
// entry memory: one write port, one registered read port
module olt_store #(
    parameter int ENTRIES = olt_pkg::ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output olt_pkg::entry_t            rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  olt_pkg::entry_t            wr_data
);

    olt_pkg::entry_t mem [ENTRIES];
    olt_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/olt_ctrl.sv -----
// search sequencer with shared key compare and update decision
module olt_ctrl #(
    parameter int ENTRIES = olt_pkg::ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic [31:0]                s_file_key,
    input  logic [15:0]                s_sentence,
    input  logic [15:0]                s_user_key,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_status,
    output logic                       m_lock_held,
    output logic                       rd_en,
    output logic [$clog2(ENTRIES)-1:0] rd_addr,
    input  olt_pkg::entry_t            rd_data,
    output logic                       wr_en,
    output logic [$clog2(ENTRIES)-1:0] wr_addr,
    output olt_pkg::entry_t            wr_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    olt_pkg::state_t state_reg, state_next;
    logic [1:0]      cmd_reg, cmd_next;
    logic [31:0]     file_reg, file_next;
    logic [15:0]     sent_reg, sent_next;
    logic [15:0]     user_reg, user_next;
    logic [CW-1:0]   issue_reg, issue_next;
    logic            chk_vld_reg, chk_vld_next;
    logic [AW-1:0]   chk_idx_reg, chk_idx_next;
    logic            hit_reg, hit_next;
    logic [AW-1:0]   hit_idx_reg, hit_idx_next;
    logic            hit_locked_reg, hit_locked_next;
    logic [15:0]     hit_owner_reg, hit_owner_next;
    logic [CW-1:0]   used_reg, used_next;
    logic            m_valid_reg, m_valid_next;
    logic [2:0]      m_status_reg, m_status_next;
    logic            m_locked_reg, m_locked_next;
    logic            key_match;
    logic            out_free;

    assign key_match = (rd_data.file_key == file_reg) && (rd_data.sentence == sent_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == olt_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= olt_pkg::ST_IDLE;
            used_reg    <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        file_reg       <= file_next;
        sent_reg       <= sent_next;
        user_reg       <= user_next;
        issue_reg      <= issue_next;
        chk_idx_reg    <= chk_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_locked_reg <= hit_locked_next;
        hit_owner_reg  <= hit_owner_next;
        m_status_reg   <= m_status_next;
        m_locked_reg   <= m_locked_next;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        file_next       = file_reg;
        sent_next       = sent_reg;
        user_next       = user_reg;
        issue_next      = issue_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_locked_next = hit_locked_reg;
        hit_owner_next  = hit_owner_reg;
        used_next       = used_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_locked_next   = m_locked_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = hit_idx_reg;
        wr_data         = '{file_key: file_reg, sentence: sent_reg,
                            locked: 1'b0, owner: 16'd0};

        case (state_reg)
            olt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    file_next  = s_file_key;
                    sent_next  = s_sentence;
                    user_next  = s_user_key;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    if (s_cmd inside {olt_pkg::CMD_LOCK, olt_pkg::CMD_UNLOCK,
                                      olt_pkg::CMD_QUERY}) begin
                        state_next = olt_pkg::ST_SCAN;
                    end else begin
                        state_next = olt_pkg::ST_DECIDE;
                    end
                end
            end

            olt_pkg::ST_SCAN: begin
                if (chk_vld_reg && key_match) begin
                    hit_next        = 1'b1;
                    hit_idx_next    = chk_idx_reg;
                    hit_locked_next = rd_data.locked;
                    hit_owner_next  = rd_data.owner;
                    state_next      = olt_pkg::ST_DECIDE;
                end else if (issue_reg < used_reg) begin
                    rd_en        = 1'b1;
                    issue_next   = issue_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = issue_reg[AW-1:0];
                end else if (!chk_vld_reg) begin
                    state_next = olt_pkg::ST_DECIDE;
                end
            end

            olt_pkg::ST_DECIDE: begin
                if (out_free) begin
                    state_next    = olt_pkg::ST_IDLE;
                    m_valid_next  = 1'b1;
                    m_status_next = olt_pkg::STATUS_OK;
                    m_locked_next = 1'b0;
                    case (cmd_reg)
                        olt_pkg::CMD_LOCK: begin
                            if (hit_reg) begin
                                if (hit_locked_reg) begin
                                    m_status_next = olt_pkg::STATUS_LOCKED;
                                end else begin
                                    wr_en          = 1'b1;
                                    wr_data.locked = 1'b1;
                                    wr_data.owner  = user_reg;
                                end
                            end else if (used_reg == FULL_COUNT) begin
                                m_status_next = olt_pkg::STATUS_FULL;
                            end else begin
                                wr_en          = 1'b1;
                                wr_addr        = used_reg[AW-1:0];
                                wr_data.locked = 1'b1;
                                wr_data.owner  = user_reg;
                                used_next      = used_reg + 1'b1;
                            end
                        end
                        olt_pkg::CMD_UNLOCK: begin
                            if (hit_reg) begin
                                if (!hit_locked_reg) begin
                                    m_status_next = olt_pkg::STATUS_NOT_LOCKED;
                                end else if (hit_owner_reg != user_reg) begin
                                    m_status_next = olt_pkg::STATUS_WRONG_OWNER;
                                end else begin
                                    wr_en = 1'b1;
                                end
                            end else if (used_reg == FULL_COUNT) begin
                                m_status_next = olt_pkg::STATUS_FULL;
                            end else begin
                                wr_en         = 1'b1;
                                wr_addr       = used_reg[AW-1:0];
                                used_next     = used_reg + 1'b1;
                                m_status_next = olt_pkg::STATUS_NOT_LOCKED;
                            end
                        end
                        olt_pkg::CMD_QUERY: begin
                            m_locked_next = hit_reg && hit_locked_reg;
                        end
                        default: begin
                            m_locked_next = 1'b0;
                        end
                    endcase
                end
            end

            default: begin
                state_next = olt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_lock_held = m_locked_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= FULL_COUNT)
        else $error("entry count beyond table size");

    a_write_in_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == olt_pkg::ST_DECIDE) && out_free)
        else $error("table write outside decision step");

    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (used_reg != $past(used_reg))
            |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("entry count moved by more than one");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == olt_pkg::ST_DECIDE) && m_valid_reg && !m_ready
            |=> (state_reg == olt_pkg::ST_DECIDE) && $stable(used_reg))
        else $error("result overwritten while stalled");

endmodule

// ----- sv/owner_lock_table.sv -----
// owner lock table top level
//
// input channel s_*: one beat carries a command (lock, unlock, query), a file
// key, a sentence number and a user key. result channel m_*: one beat per
// input beat with a status code and, for query, the locked flag.
// the entry memory is searched linearly, one entry per cycle through its
// registered read port. with N filled entries (at most ENTRIES) a request
// that misses reads all N entries before its result beat, a hit stops at
// the matching entry; the next input beat is taken only after the result
// beat of the last request has been issued.
// lock and unlock that miss append a new entry at the end unless the table is full.
// s_ready is high only while no request is in progress, so one request is
// worked on at a time; a new request is taken while the last result waits
// in the output register.
// if m_ready stays low the finished request holds in its decision step and
// writes nothing until the output register frees.
// reset empties the table by clearing the fill count; memory contents are
// not cleared and entries past the fill count are never read.
module owner_lock_table #(
    parameter int ENTRIES = olt_pkg::ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_file_key,
    input  logic [15:0] s_sentence,
    input  logic [15:0] s_user_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_lock_held
);

    localparam int AW = $clog2(ENTRIES);

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    olt_pkg::entry_t rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    olt_pkg::entry_t wr_data;

    olt_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_file_key  (s_file_key),
        .s_sentence  (s_sentence),
        .s_user_key  (s_user_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_lock_held (m_lock_held),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    olt_store #(
        .ENTRIES(ENTRIES)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule
